// File: sv/record_table_sort_search_macros.svh
// Assertion macros for the record table block.
`ifndef RECORD_TABLE_SORT_SEARCH_MACROS_SVH
`define RECORD_TABLE_SORT_SEARCH_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define RTS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("record table check failed");
// Next-cycle implication, checked out of reset.
`define RTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("record table check failed");
`else
`define RTS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define RTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/rts_pkg.sv
// Shared types and codes for the record table block.
package rts_pkg;

  // One stored record
  typedef struct packed {
    logic [31:0] id;
    logic [15:0] score;
    logic [63:0] tag;
  } rec_t;

  typedef enum logic [2:0] {
    CMD_APPEND = 3'd0,
    CMD_LIST   = 3'd1,
    CMD_SORT   = 3'd2,
    CMD_SEARCH = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_BADCMD   = 3'd4
  } status_t;

  // Operations of the shared compare unit
  typedef enum logic {
    CMP_GT = 1'b0,
    CMP_EQ = 1'b1
  } cmp_op_t;

endpackage

// File: sv/record_table_sort_search.sv
// Record table: append, list, stable bubble sort by score, id search, clear.
// Append, clear, bad command, every command on an empty table and sort on a
// one-entry table: one result in the cycle after start, busy stays low.
// List: each record is read in S_LRD and sent in S_LOUT. Search: each entry visited is
// read in S_SRD and compared in S_SCMP. Sort: passes, repeated until a pass makes no swap.
// Reset clears the entry count and the control state; record contents are undefined.
`include "record_table_sort_search_macros.svh"
module record_table_sort_search
  import rts_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_cmd,
  input  logic signed [31:0] in_record_id,
  input  logic signed [15:0] in_score,
  input  logic [63:0]        in_record_tag,
  output logic               out_strobe,
  output logic [2:0]         out_status,
  output logic signed [31:0] out_id,
  output logic signed [15:0] out_score,
  output logic [63:0]        out_tag,
  output logic               out_last
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LRD,
    S_LOUT,
    S_SRD,
    S_SCMP,
    S_BLD,
    S_BHD,
    S_BRD,
    S_BCMP,
    S_BEND
  } state_t;

  state_t         state_r;
  logic [CW-1:0]  count_r;
  logic [AW-1:0]  idx_r;
  logic [31:0]    key_r;
  rec_t           hold_r;
  logic           swapped_r;
  logic           out_strobe_r;
  status_t        status_r;
  rec_t           res_r;
  logic           last_r;

  logic           accept;
  logic           full;
  logic           at_last;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  rec_t           mem_wdata;
  logic [AW-1:0]  mem_raddr;
  rec_t           rd_data;
  cmp_op_t        cmp_op;
  logic [31:0]    cmp_a;
  logic [31:0]    cmp_b;
  logic           cmp_hit;

  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign full    = (count_r == CW'(DEPTH));
  assign at_last = ((CW'(idx_r) + CW'(1)) == count_r);

  rts_mem #(.DEPTH(DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  rts_cmp u_cmp (
    .op  (cmp_op),
    .a   (cmp_a),
    .b   (cmp_b),
    .hit (cmp_hit)
  );

  // Compare operands: score order while sorting, id match otherwise
  always_comb begin
    if (state_r == S_BCMP) begin
      cmp_op = CMP_GT;
      cmp_a  = {{16{hold_r.score[15]}}, hold_r.score};
      cmp_b  = {{16{rd_data.score[15]}}, rd_data.score};
    end else begin
      cmp_op = CMP_EQ;
      cmp_a  = rd_data.id;
      cmp_b  = key_r;
    end
  end

  // Memory port steering
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r - AW'(1);
    mem_wdata = hold_r;
    mem_raddr = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_cmd == CMD_APPEND && !full) begin
          mem_we    = 1'b1;
          mem_waddr = count_r[AW-1:0];
          mem_wdata = '{id: in_record_id, score: in_score, tag: in_record_tag};
        end
      end
      S_BLD:  mem_raddr = '0;
      S_BCMP: begin
        // smaller record settles one slot down; larger one rides on
        mem_we    = 1'b1;
        mem_wdata = cmp_hit ? rd_data : hold_r;
      end
      S_BEND: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(count_r - CW'(1));
      end
      default: ;
    endcase
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            res_r  <= '0;
            last_r <= 1'b1;
            idx_r  <= '0;
            key_r  <= in_record_id;
            unique case (cmd_t'(in_cmd))
              CMD_APPEND: begin
                out_strobe_r <= 1'b1;
                if (full) begin
                  status_r <= ST_FULL;
                end else begin
                  status_r <= ST_OK;
                  count_r  <= count_r + CW'(1);
                end
              end
              CMD_LIST, CMD_SEARCH, CMD_SORT: begin
                if (count_r == '0) begin
                  out_strobe_r <= 1'b1;
                  status_r     <= ST_EMPTY;
                end else if (in_cmd == CMD_LIST) begin
                  state_r <= S_LRD;
                end else if (in_cmd == CMD_SEARCH) begin
                  state_r <= S_SRD;
                end else if (count_r == CW'(1)) begin
                  out_strobe_r <= 1'b1;
                  status_r     <= ST_OK;
                end else begin
                  state_r <= S_BLD;
                end
              end
              CMD_CLEAR: begin
                out_strobe_r <= 1'b1;
                status_r     <= ST_OK;
                count_r      <= '0;
              end
              default: begin
                out_strobe_r <= 1'b1;
                status_r     <= ST_BADCMD;
              end
            endcase
          end
        end
        S_LRD: state_r <= S_LOUT;
        S_LOUT: begin
          out_strobe_r <= 1'b1;
          status_r     <= ST_OK;
          res_r        <= rd_data;
          last_r       <= at_last;
          idx_r        <= idx_r + AW'(1);
          state_r      <= at_last ? S_IDLE : S_LRD;
        end
        S_SRD: state_r <= S_SCMP;
        S_SCMP: begin
          if (cmp_hit) begin
            out_strobe_r <= 1'b1;
            status_r     <= ST_OK;
            res_r        <= rd_data;
            state_r      <= S_IDLE;
          end else if (at_last) begin
            out_strobe_r <= 1'b1;
            status_r     <= ST_NOTFOUND;
            state_r      <= S_IDLE;
          end else begin
            idx_r   <= idx_r + AW'(1);
            state_r <= S_SRD;
          end
        end
        // Sort pass: carry the larger record upward through the table
        S_BLD: begin
          idx_r     <= AW'(1);
          swapped_r <= 1'b0;
          state_r   <= S_BHD;
        end
        S_BHD: begin
          hold_r  <= rd_data;
          state_r <= S_BRD;
        end
        S_BRD: state_r <= S_BCMP;
        S_BCMP: begin
          if (cmp_hit) begin
            swapped_r <= 1'b1;
          end else begin
            hold_r <= rd_data;
          end
          if (at_last) begin
            state_r <= S_BEND;
          end else begin
            idx_r   <= idx_r + AW'(1);
            state_r <= S_BRD;
          end
        end
        S_BEND: begin
          if (swapped_r) begin
            state_r <= S_BLD;
          end else begin
            out_strobe_r <= 1'b1;
            status_r     <= ST_OK;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_status = status_r;
  assign out_id     = res_r.id;
  assign out_score  = res_r.score;
  assign out_tag    = res_r.tag;
  assign out_last   = last_r;

  // Checks
  `RTS_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(DEPTH))
  `RTS_ASSERT_NEXT(a_list_continues, clk, rst_n, out_strobe && !out_last, busy)
  `RTS_ASSERT_SAME(a_err_is_last, clk, rst_n, out_strobe && out_status != ST_OK, out_last)
  `RTS_ASSERT_SAME(a_walk_in_range, clk, rst_n,
                   state_r == S_BCMP || state_r == S_SCMP || state_r == S_LOUT,
                   CW'(idx_r) < count_r)
  `RTS_ASSERT_NEXT(a_quick_reply, clk, rst_n,
                   accept && (in_cmd == CMD_APPEND || in_cmd == CMD_CLEAR),
                   out_strobe && out_last && !busy)

endmodule

// File: sv/rts_mem.sv
// Record storage: one write port, one registered read port.
module rts_mem
  import rts_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  rec_t                     wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output rec_t                     rdata
);

  rec_t mem [DEPTH];
  rec_t rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/rts_cmp.sv
// Shared compare unit: signed greater-than or equality on 32-bit operands.
module rts_cmp
  import rts_pkg::*;
(
  input  cmp_op_t            op,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic               hit
);

  always_comb begin
    unique case (op)
      CMP_GT:  hit = (a > b);
      CMP_EQ:  hit = (a == b);
      default: hit = 1'b0;
    endcase
  end

endmodule
